FILE: rtl/core/first_fit_block_allocator_unit_assert.svh
// Assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
// assert that a implies b in the same cycle
`define FFBA_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b in the next cycle
`define FFBA_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/ffba_pkg.sv
// Package: constants, codes and types for the first-fit block allocator
package ffba_pkg;
  localparam int unsigned BufBytesDef   = 4096;
  localparam int unsigned TableDepthDef = 32;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_END, S_MOVE, S_MERGE, S_DONE
  } state_e;

  // per-cycle control shared by all cells
  typedef enum logic [2:0] {
    OP_HOLD, OP_SHIFT_UP, OP_SHIFT_DN, OP_WRITE
  } op_e;
endpackage

FILE: rtl/core/ffba_cell.sv
// One table slot: start, length, free mark; can load from either neighbor
module ffba_cell
  import ffba_pkg::*;
#(
  parameter int unsigned AW = 12,
  parameter int unsigned LW = 13
) (
  input  logic          clk_i,
  input  logic          ld_lo_i,   // take lower neighbor
  input  logic          ld_hi_i,   // take upper neighbor
  input  logic          ld_w_i,    // take write data
  input  logic [AW-1:0] lo_start_i,
  input  logic [LW-1:0] lo_len_i,
  input  logic          lo_free_i,
  input  logic [AW-1:0] hi_start_i,
  input  logic [LW-1:0] hi_len_i,
  input  logic          hi_free_i,
  input  logic [AW-1:0] w_start_i,
  input  logic [LW-1:0] w_len_i,
  input  logic          w_free_i,
  output logic [AW-1:0] start_o,
  output logic [LW-1:0] len_o,
  output logic          free_o
);
  logic [AW-1:0] start_q;
  logic [LW-1:0] len_q;
  logic          free_q;

  always_ff @(posedge clk_i) begin
    if (ld_w_i) begin
      start_q <= w_start_i; len_q <= w_len_i; free_q <= w_free_i;
    end else if (ld_lo_i) begin
      start_q <= lo_start_i; len_q <= lo_len_i; free_q <= lo_free_i;
    end else if (ld_hi_i) begin
      start_q <= hi_start_i; len_q <= hi_len_i; free_q <= hi_free_i;
    end
  end

  assign start_o = start_q;
  assign len_o   = len_q;
  assign free_o  = free_q;
endmodule

FILE: rtl/core/first_fit_block_allocator_unit.sv
// Top level: first-fit block allocator built from a chain of table cells
//
//  channel | dir | valid / ready          | payload
//  --------+-----+------------------------+---------------------------------
//  in      | in  | in_valid_i/in_ready_o  | cmd_i, req_length_i, free_offset_i
//  out     | out | out_valid_o/out_ready_i| status_o, alloc_offset_o
//
// A word is handled one at a time. The scan walks entries one per cycle,
// then a split or merge shifts the cell chain one slot per cycle over the
// tail. Reset clears only the entry count and control; cell contents are
// don't-care until written. The result sits in an output register; a stall
// on out holds it and blocks the next word.
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [12:0] req_length_i,
  input  logic [11:0] free_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [11:0] alloc_offset_o
);
`include "first_fit_block_allocator_unit_assert.svh"
  // buffer size is fixed by the port widths
  localparam int unsigned BUF_BYTES = BufBytesDef;
  localparam int unsigned AW = 12;
  localparam int unsigned LW = 13;
  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $clog2(BUF_BYTES + 1) + 1;

  // cell outputs
  logic [AW-1:0] c_start [TABLE_DEPTH];
  logic [LW-1:0] c_len   [TABLE_DEPTH];
  logic          c_free  [TABLE_DEPTH];
  logic          ld_lo   [TABLE_DEPTH];
  logic          ld_hi   [TABLE_DEPTH];
  logic          ld_w    [TABLE_DEPTH];

  state_e state_q, state_d;
  op_e    op;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] idx_q, idx_d;     // scan position / found entry
  logic [CW-1:0] mv_q, mv_d;       // shift cursor
  logic          cmd_q;
  logic [LW-1:0] len_q;
  logic [AW-1:0] off_q;
  logic [1:0]    status_q, status_d;
  logic [AW-1:0] aoff_q, aoff_d;
  logic          valid_q, valid_d;
  logic          mrg_prev_q, mrg_prev_d; // merge with previous still to do
  logic          split_q, split_d;       // shift is for a split insert
  // write port
  logic [IW-1:0] w_idx;
  logic          w_en;
  logic [AW-1:0] w_start;
  logic [LW-1:0] w_len;
  logic          w_free;
  logic [IW-1:0] w2_idx;
  logic          w2_en;
  logic [LW-1:0] w2_len;
  logic          w2_free;
  logic [AW-1:0] w2_start;

  logic [IW-1:0] cur;
  logic [AW-1:0] cur_start;
  logic [LW-1:0] cur_len;
  logic          cur_free;
  logic [EW-1:0] end_pos;

  assign cur       = idx_q[IW-1:0];
  assign cur_start = c_start[cur];
  assign cur_len   = c_len[cur];
  assign cur_free  = c_free[cur];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam int unsigned GL = (g == 0) ? 0 : g - 1;
    localparam int unsigned GH = (g == TABLE_DEPTH - 1) ? g : g + 1;
    always_comb begin
      ld_w[g]  = (w_en && w_idx == IW'(g)) || (w2_en && w2_idx == IW'(g));
      ld_lo[g] = (op == OP_SHIFT_UP) && (g != 0) && (CW'(g) == mv_q);
      ld_hi[g] = (op == OP_SHIFT_DN) && (CW'(g) == mv_q);
    end
    ffba_cell #(.AW(AW), .LW(LW)) u_cell (
      .clk_i      (clk_i),
      .ld_lo_i    (ld_lo[g]),
      .ld_hi_i    (ld_hi[g]),
      .ld_w_i     (ld_w[g]),
      .lo_start_i (c_start[GL]),
      .lo_len_i   (c_len[GL]),
      .lo_free_i  (c_free[GL]),
      .hi_start_i (c_start[GH]),
      .hi_len_i   (c_len[GH]),
      .hi_free_i  (c_free[GH]),
      .w_start_i  ((w2_en && w2_idx == IW'(g)) ? w2_start : w_start),
      .w_len_i    ((w2_en && w2_idx == IW'(g)) ? w2_len : w_len),
      .w_free_i   ((w2_en && w2_idx == IW'(g)) ? w2_free : w_free),
      .start_o    (c_start[g]),
      .len_o      (c_len[g]),
      .free_o     (c_free[g])
    );
  end

  logic [IW-1:0] last;
  assign last = IW'(used_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    mv_q       <= mv_d;
    status_q   <= status_d;
    aoff_q     <= aoff_d;
    mrg_prev_q <= mrg_prev_d;
    split_q    <= split_d;
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i;
      len_q <= req_length_i;
      off_q <= free_offset_i;
    end
  end

  assign end_pos = (used_q == '0) ? '0 :
                   EW'(c_start[last]) + EW'(c_len[last]);

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    idx_d      = idx_q;
    mv_d       = mv_q;
    status_d   = status_q;
    aoff_d     = aoff_q;
    valid_d    = valid_q;
    mrg_prev_d = mrg_prev_q;
    split_d    = split_q;
    op         = OP_HOLD;
    w_en = 1'b0; w_idx = cur; w_start = cur_start; w_len = cur_len; w_free = cur_free;
    w2_en = 1'b0; w2_idx = cur; w2_start = cur_start; w2_len = cur_len; w2_free = cur_free;
    in_ready_o = 1'b0;
    if (valid_q && out_ready_i) valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          idx_d = '0;
          aoff_d = '0;
          if (cmd_i == CMD_ALLOC && (req_length_i == '0 ||
              EW'(req_length_i) > EW'(BUF_BYTES))) begin
            status_d = ST_NO_SPACE;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q >= used_q) begin
          if (cmd_q == CMD_FREE) begin
            status_d = ST_NOT_FOUND; state_d = S_DONE;
          end else begin
            state_d = S_END;
          end
        end else if (cmd_q == CMD_ALLOC) begin
          if (cur_free && cur_len >= len_q) begin
            if (cur_len > len_q) begin
              if (used_q >= CW'(TABLE_DEPTH)) begin
                status_d = ST_TABLE_FULL; state_d = S_DONE;
              end else begin
                split_d = 1'b1; mv_d = used_q; state_d = S_MOVE;
              end
            end else begin
              w_en = 1'b1; w_free = 1'b0;
              status_d = ST_OK; aoff_d = cur_start; state_d = S_DONE;
            end
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end else begin
          if (cur_start == off_q) begin
            if (cur_free) begin
              status_d = ST_NOT_FOUND; state_d = S_DONE;
            end else begin
              // mark free, merge with next if free
              w_en = 1'b1; w_free = 1'b1;
              status_d = ST_OK;
              mrg_prev_d = (idx_q != '0);
              split_d = 1'b0;
              if (idx_q + CW'(1) < used_q && c_free[IW'(idx_q + CW'(1))]) begin
                w_len = cur_len + c_len[IW'(idx_q + CW'(1))];
                mv_d = idx_q + CW'(1);
                state_d = S_MOVE;
              end else begin
                state_d = S_MERGE;
              end
            end
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end
      S_END: begin
        if (end_pos + EW'(len_q) > EW'(BUF_BYTES)) begin
          status_d = ST_NO_SPACE;
        end else if (used_q >= CW'(TABLE_DEPTH)) begin
          status_d = ST_TABLE_FULL;
        end else begin
          w_en = 1'b1; w_idx = IW'(used_q);
          w_start = AW'(end_pos); w_len = len_q; w_free = 1'b0;
          used_d = used_q + CW'(1);
          status_d = ST_OK; aoff_d = AW'(end_pos);
        end
        state_d = S_DONE;
      end
      S_MOVE: begin
        if (split_q) begin
          // shift up into mv, down to idx+2, then write the pair
          if (mv_q > idx_q + CW'(1)) begin
            op = OP_SHIFT_UP; mv_d = mv_q - CW'(1);
          end else begin
            w_en = 1'b1; w_len = len_q; w_free = 1'b0;
            w2_en = 1'b1; w2_idx = IW'(idx_q + CW'(1));
            w2_start = cur_start + AW'(len_q);
            w2_len = cur_len - len_q; w2_free = 1'b1;
            used_d = used_q + CW'(1);
            status_d = ST_OK; aoff_d = cur_start;
            state_d = S_DONE;
          end
        end else begin
          // close the gap at mv by pulling the tail down
          if (mv_q + CW'(1) < used_q) begin
            op = OP_SHIFT_DN; mv_d = mv_q + CW'(1);
          end else begin
            used_d = used_q - CW'(1);
            state_d = S_MERGE;
          end
        end
      end
      S_MERGE: begin
        if (mrg_prev_q && c_free[IW'(idx_q - CW'(1))]) begin
          w_en = 1'b1; w_idx = IW'(idx_q - CW'(1));
          w_start = c_start[IW'(idx_q - CW'(1))];
          w_len = c_len[IW'(idx_q - CW'(1))] + cur_len;
          w_free = 1'b1;
          mrg_prev_d = 1'b0; split_d = 1'b0;
          mv_d = idx_q; state_d = S_MOVE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!valid_q || out_ready_i) begin
          valid_d = 1'b1;
          if (status_d != ST_OK) aoff_d = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o    = valid_q;
  assign status_o       = status_q;
  assign alloc_offset_o = aoff_q;

  `FFBA_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, used_q <= CW'(TABLE_DEPTH))
  `FFBA_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == S_IDLE)
  `FFBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(alloc_offset_o))
  `FFBA_ASSERT_IMP(a_fail_off, clk_i, rst_ni,
    out_valid_o && status_o != ST_OK, alloc_offset_o == '0)
endmodule
